// ----- rtl/md5bsh_pkg.sv -----
// shared types, constants and step tables of the md5 byte stream hasher
// no dependencies; used by md5bsh_step, md5bsh_block_buf and the top level
`default_nettype none

package md5bsh_pkg;

   localparam int WORD_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 64;
   localparam int STEP_W  = 6;
   localparam int WIDX_W  = 4;
   localparam int POS_W   = 6;

   localparam logic FUNC_BYTE   = 1'b0;
   localparam logic FUNC_FINISH = 1'b1;

   // first byte position that pushes the length into an extra block
   localparam logic [POS_W-1:0] PAD_SPILL_POS = 6'd56;
   localparam logic [STEP_W-1:0] LAST_STEP    = 6'd63;
   localparam logic [BYTE_W-1:0] PAD_MARKER   = 8'h80;

   localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
   localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
   localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
   localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPRESS,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      BLK_DATA,       // plain 64-byte message block
      BLK_PAD_FIRST,  // block holding the 0x80 marker
      BLK_PAD_LEN     // extra block holding only the length
   } blk_mode_type;

   typedef struct packed {
      blk_mode_type         mode;
      logic [POS_W-1:0]     pos;
      logic [COUNT_W-1:0]   bit_len;
   } pad_ctrl_type;

   typedef logic [WORD_W-1:0] word_type;

   function automatic word_type step_const(input logic [STEP_W-1:0] i);
      word_type k;
      case (i)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [STEP_W-1:0] i);
      logic [4:0] s;
      case ({i[5:4], i[1:0]})
         4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
         4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
         4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
         4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
         default: s = 5'd0;
      endcase
      return s;
   endfunction

   // message word used by step i
   function automatic logic [WIDX_W-1:0] msg_index(input logic [STEP_W-1:0] i);
      logic [WIDX_W-1:0] j;
      logic [WIDX_W-1:0] g;
      j = i[3:0];
      case (i[5:4])
         2'd0:    g = j;
         2'd1:    g = j * 4'd5 + 4'd1;
         2'd2:    g = j * 4'd3 + 4'd5;
         2'd3:    g = j * 4'd7;
         default: g = j;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/md5bsh_step.sv -----
// one md5 step: boolean function, four-way add and left rotate
// depends on md5bsh_pkg for the step constant and rotate tables
`default_nettype none

module md5bsh_step (
   input  wire logic [md5bsh_pkg::STEP_W-1:0] step_idx,
   input  wire md5bsh_pkg::word_type          a_in,
   input  wire md5bsh_pkg::word_type          b_in,
   input  wire md5bsh_pkg::word_type          c_in,
   input  wire md5bsh_pkg::word_type          d_in,
   input  wire md5bsh_pkg::word_type          msg_word,
   output md5bsh_pkg::word_type               b_out
);
   import md5bsh_pkg::*;

   word_type                f_val;
   word_type                sum;
   logic [4:0]              shamt;
   logic [2*WORD_W-1:0]     rot_wide;

   always_comb begin
      case (step_idx[5:4])
         2'd0:    f_val = d_in ^ (b_in & (c_in ^ d_in));
         2'd1:    f_val = c_in ^ (d_in & (b_in ^ c_in));
         2'd2:    f_val = b_in ^ c_in ^ d_in;
         2'd3:    f_val = c_in ^ (b_in | ~d_in);
         default: f_val = '0;
      endcase
      sum      = a_in + f_val + step_const(step_idx) + msg_word;
      shamt    = rot_amount(step_idx);
      rot_wide = {sum, sum} << shamt;
      b_out    = b_in + rot_wide[2*WORD_W-1:WORD_W];
   end

endmodule

`default_nettype wire

// ----- rtl/md5bsh_block_buf.sv -----
// 16-word message block buffer with byte write and padded word read
// depends on md5bsh_pkg for the padding control struct
`default_nettype none

module md5bsh_block_buf (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [md5bsh_pkg::POS_W-1:0]  wr_pos,
   input  wire logic [md5bsh_pkg::BYTE_W-1:0] wr_byte,
   input  wire logic [md5bsh_pkg::WIDX_W-1:0] rd_idx,
   input  wire md5bsh_pkg::pad_ctrl_type      pad_ctrl,
   output md5bsh_pkg::word_type               rd_word
);
   import md5bsh_pkg::*;

   word_type block_ff [16];

   logic [WIDX_W-1:0] pad_w;
   logic [1:0]        pad_lane;
   word_type          stored;
   word_type          keep_mask;
   word_type          marker;
   logic              len_slot;
   word_type          len_word;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         block_ff[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: BYTE_W] <= wr_byte;
      end
   end

   always_comb begin
      pad_w    = pad_ctrl.pos[5:2];
      pad_lane = pad_ctrl.pos[1:0];
      stored   = block_ff[rd_idx];
      case (pad_lane)
         2'd0:    keep_mask = 32'h0000_0000;
         2'd1:    keep_mask = 32'h0000_00ff;
         2'd2:    keep_mask = 32'h0000_ffff;
         2'd3:    keep_mask = 32'h00ff_ffff;
         default: keep_mask = '0;
      endcase
      marker   = {24'd0, PAD_MARKER} << {pad_lane, 3'b000};
      len_slot = (rd_idx == 4'd14) || (rd_idx == 4'd15);
      len_word = rd_idx[0] ? pad_ctrl.bit_len[63:32] : pad_ctrl.bit_len[31:0];
      case (pad_ctrl.mode)
         BLK_DATA: rd_word = stored;
         BLK_PAD_FIRST: begin
            if (len_slot && (pad_ctrl.pos < PAD_SPILL_POS)) begin
               rd_word = len_word;
            end else if (rd_idx < pad_w) begin
               rd_word = stored;
            end else if (rd_idx == pad_w) begin
               rd_word = (stored & keep_mask) | marker;
            end else begin
               rd_word = '0;
            end
         end
         BLK_PAD_LEN: rd_word = len_slot ? len_word : '0;
         default: rd_word = stored;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/md5_byte_stream_hasher_top.sv -----
// top level of the md5 byte stream hasher: sequencer, chaining words, output
// depends on md5bsh_pkg, md5bsh_step and md5bsh_block_buf
`default_nettype none

// MD5 over a byte stream. Each request word carries one message byte
// (req_tuser = 0) or a finish command (req_tuser = 1). A byte is taken
// whenever the block is idle; the byte that completes a 64-byte block
// starts compression, in which the single shared step unit runs one MD5
// step per cycle. Finish pads the message and compresses one block, or
// two when 56 or more bytes of the last block are pending, then presents
// the four digest words on the response channel, low word first
// (rsp_tuser is the word index, rsp_tlast marks word 3). req_tready is
// low throughout compression and digest output. After the last digest
// word is taken the chaining words and byte count return to their initial
// values and a new message may start.
module md5_byte_stream_hasher_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] digest_word
   output logic [1:0]       rsp_tuser,   // [1:0] word_index
   output logic             rsp_tlast    // last_word
);
   import md5bsh_pkg::*;

   // sequencer and block state
   state_type             state_ff, state_in;
   blk_mode_type          mode_ff, mode_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [1:0]            widx_ff, widx_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   word_type              chain_ff [4];
   word_type              chain_in [4];

   // working registers of the compression
   word_type              wa_ff, wb_ff, wc_ff, wd_ff;
   word_type              wa_in, wb_in, wc_in, wd_in;

   logic                  req_accept;
   logic                  buf_wr_en;
   pad_ctrl_type          pad_ctrl;
   word_type              msg_word;
   word_type              step_b;
   word_type              sum_a, sum_b, sum_c, sum_d;

   assign req_accept = req_tvalid && req_tready;

   assign pad_ctrl.mode    = mode_ff;
   assign pad_ctrl.pos     = count_ff[POS_W-1:0];
   assign pad_ctrl.bit_len = {count_ff[COUNT_W-4:0], 3'b000};

   md5bsh_block_buf u_block_buf (
      .clock    (clock),
      .wr_en    (buf_wr_en),
      .wr_pos   (count_ff[POS_W-1:0]),
      .wr_byte  (req_tdata),
      .rd_idx   (msg_index(step_ff)),
      .pad_ctrl (pad_ctrl),
      .rd_word  (msg_word)
   );

   md5bsh_step u_step (
      .step_idx (step_ff),
      .a_in     (wa_ff),
      .b_in     (wb_ff),
      .c_in     (wc_ff),
      .d_in     (wd_ff),
      .msg_word (msg_word),
      .b_out    (step_b)
   );

   // chaining update after the last step (a,c,d rotate in from d,b,c)
   assign sum_a = chain_ff[0] + wd_ff;
   assign sum_b = chain_ff[1] + step_b;
   assign sum_c = chain_ff[2] + wb_ff;
   assign sum_d = chain_ff[3] + wc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         mode_ff     <= BLK_DATA;
         step_ff     <= '0;
         widx_ff     <= '0;
         count_ff    <= '0;
         chain_ff[0] <= IV_A;
         chain_ff[1] <= IV_B;
         chain_ff[2] <= IV_C;
         chain_ff[3] <= IV_D;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         step_ff  <= step_in;
         widx_ff  <= widx_in;
         count_ff <= count_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff <= wa_in;
      wb_ff <= wb_in;
      wc_ff <= wc_in;
      wd_ff <= wd_in;
   end

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      step_in    = step_ff;
      widx_in    = widx_ff;
      count_in   = count_ff;
      chain_in   = chain_ff;
      wa_in      = wa_ff;
      wb_in      = wb_ff;
      wc_in      = wc_ff;
      wd_in      = wd_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      buf_wr_en  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               // working registers start from the chaining words
               wa_in   = chain_ff[0];
               wb_in   = chain_ff[1];
               wc_in   = chain_ff[2];
               wd_in   = chain_ff[3];
               step_in = '0;
               if (req_tuser == FUNC_BYTE) begin
                  buf_wr_en = 1'b1;
                  count_in  = count_ff + 64'd1;
                  mode_in   = BLK_DATA;
                  // block full: compress it
                  if (count_ff[POS_W-1:0] == LAST_STEP) begin
                     state_in = ST_COMPRESS;
                  end
               end else begin
                  mode_in  = BLK_PAD_FIRST;
                  state_in = ST_COMPRESS;
               end
            end
         end

         ST_COMPRESS: begin
            step_in = step_ff + 6'd1;
            wa_in   = wd_ff;
            wb_in   = step_b;
            wc_in   = wb_ff;
            wd_in   = wc_ff;
            if (step_ff == LAST_STEP) begin
               chain_in[0] = sum_a;
               chain_in[1] = sum_b;
               chain_in[2] = sum_c;
               chain_in[3] = sum_d;
               // next block, if any, starts from the new chaining words
               wa_in = sum_a;
               wb_in = sum_b;
               wc_in = sum_c;
               wd_in = sum_d;
               if (mode_ff == BLK_PAD_FIRST && count_ff[POS_W-1:0] >= PAD_SPILL_POS) begin
                  mode_in = BLK_PAD_LEN;
               end else if (mode_ff == BLK_DATA) begin
                  state_in = ST_IDLE;
               end else begin
                  widx_in  = '0;
                  state_in = ST_EMIT;
               end
            end
         end

         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               widx_in = widx_ff + 2'd1;
               if (widx_ff == 2'd3) begin
                  // digest delivered: back to initial state
                  chain_in[0] = IV_A;
                  chain_in[1] = IV_B;
                  chain_in[2] = IV_C;
                  chain_in[3] = IV_D;
                  count_in    = '0;
                  mode_in     = BLK_DATA;
                  state_in    = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tdata = chain_ff[widx_ff];
   assign rsp_tuser = widx_ff;
   assign rsp_tlast = (widx_ff == 2'd3);

endmodule

`default_nettype wire

// ----- rtl/md5bsh_checker.sv -----
// port-level checker for the md5 byte stream hasher, bound to the top level
// depends on md5_byte_stream_hasher_top port names only
`default_nettype none

module md5bsh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // a stalled digest word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("digest word changed while stalled");

   // no new message word is taken while the digest is presented
   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request ready during digest output");

   // a taken message byte is not directly followed by a result
   a_byte_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> !rsp_tvalid)
      else $error("result after message byte");

   // digest words come in order and stop after the last
   a_word_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast
         |=> rsp_tvalid && rsp_tuser == $past(rsp_tuser) + 2'd1)
      else $error("digest word index out of order");

   a_last_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && rsp_tuser == 2'd0)
      else $error("output continued after last digest word");

endmodule

bind md5_byte_stream_hasher_top md5bsh_checker u_md5bsh_checker (.*);

`default_nettype wire
